// ===== src/dstg_pkg.sv =====
// ----------------------------------------------------------------------------
// dstg_pkg: shared types and constants of the decaying square tone generator
// Field widths, stream word layout and the word types exchanged by the blocks.
// ----------------------------------------------------------------------------
package dstg_pkg;

  localparam int unsigned FREQ_W      = 15;  // tone frequency in Hz
  localparam int unsigned LEN_W       = 22;  // beep length / cursor
  localparam int unsigned PHASE_W     = 16;  // phase accumulator, below the sample rate
  localparam int unsigned SMP_W       = 14;  // signed sample
  localparam int unsigned MAG_W       = 15;  // quotient bits, covers the peak amplitude
  localparam int unsigned PROD_W      = MAG_W + LEN_W;
  localparam int unsigned CSUB_W      = LEN_W + 1;
  localparam int unsigned CNT_W       = 4;   // divider step counter, holds MAG_W - 1
  localparam int unsigned IN_TDATA_W  = 40;  // FREQ_W + LEN_W padded to bytes
  localparam int unsigned OUT_TDATA_W = 16;  // SMP_W padded to bytes

  localparam logic [MAG_W-1:0] SMP_MAX_MAG = MAG_W'(8191);

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef struct packed {
    logic              op;
    logic [FREQ_W-1:0] freq_hz;
    logic [LEN_W-1:0]  duration_samples;
  } item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    active;
  } result_t;

endpackage

// ===== src/dstg_csub.sv =====
// ----------------------------------------------------------------------------
// dstg_csub: shared compare-and-subtract unit
// Subtract b from a when a >= b; otherwise pass a. Serves the divider steps,
// the frequency reduction and the phase wrap.
// ----------------------------------------------------------------------------
module dstg_csub
  import dstg_pkg::*;
(
  input  logic [CSUB_W-1:0] a_i,
  input  logic [CSUB_W-1:0] b_i,
  output logic [CSUB_W-1:0] res_o,
  output logic              ge_o
);

  logic [CSUB_W:0] diff;

  assign diff  = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o  = ~diff[CSUB_W];
  assign res_o = ge_o ? diff[CSUB_W-1:0] : a_i;

endmodule

// ===== src/dstg_engine.sv =====
// ----------------------------------------------------------------------------
// dstg_engine: beep state and per-word sequencer
// Hold the beep state, run the serial divider for the decay magnitude and
// advance the phase, all through one compare-and-subtract unit.
// ----------------------------------------------------------------------------
module dstg_engine
  import dstg_pkg::*;
#(
  parameter int unsigned FS_HZ          = 44100,
  parameter int unsigned PEAK_AMPLITUDE = 8000
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    ready_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    res_take_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FREQ  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_PHASE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [CSUB_W-1:0] RATE_EXT = CSUB_W'(FS_HZ);
  localparam logic [MAG_W-1:0]  PEAK_V   = MAG_W'(PEAK_AMPLITUDE);
  localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(MAG_W - 1);

  logic [2:0]         state_q, state_d;
  logic               playing_q;
  logic [LEN_W-1:0]   cursor_q;
  logic [LEN_W-1:0]   length_q;
  logic [PHASE_W-1:0] phase_q;
  logic [PHASE_W-1:0] step_q;
  logic [LEN_W-1:0]   rem_q;
  logic [MAG_W-1:0]   dvd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               pos_q;
  result_t            res_q;

  logic               accept;
  logic               sounding;
  logic [LEN_W-1:0]   remain;
  logic [PROD_W-1:0]  prod;
  logic [CSUB_W-1:0]  cs_a, cs_b, cs_res;
  logic               cs_ge;
  logic [MAG_W-1:0]   mag_sat;
  logic [SMP_W-1:0]   mag_smp;

  assign ready_o     = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;
  assign accept      = ready_o & item_valid_i;
  assign sounding    = playing_q & (cursor_q < length_q);
  assign remain      = length_q - cursor_q;
  assign prod        = PROD_W'(PEAK_V) * PROD_W'(remain);

  assign mag_sat = (dvd_q > SMP_MAX_MAG) ? SMP_MAX_MAG : dvd_q;
  assign mag_smp = mag_sat[SMP_W-1:0];

  always_comb begin
    cs_a = '0;
    cs_b = RATE_EXT;
    case (state_q)
      ST_FREQ:  cs_a = CSUB_W'(step_q);
      ST_DIV: begin
        cs_a = {rem_q, dvd_q[MAG_W-1]};
        cs_b = CSUB_W'(length_q);
      end
      ST_PHASE: cs_a = CSUB_W'(phase_q) + CSUB_W'(step_q);
      default:  cs_a = '0;
    endcase
  end

  dstg_csub u_csub (
    .a_i   (cs_a),
    .b_i   (cs_b),
    .res_o (cs_res),
    .ge_o  (cs_ge)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_i.op == OP_START) begin
            state_d = ST_FREQ;
          end else if (sounding) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_FREQ:  if (!cs_ge) state_d = ST_IDLE;
      ST_DIV:   if (cnt_q == LAST_CNT) state_d = ST_PHASE;
      ST_PHASE: state_d = ST_DONE;
      ST_DONE:  if (res_take_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      playing_q <= 1'b0;
      cursor_q  <= '0;
      length_q  <= '0;
      phase_q   <= '0;
      step_q    <= '0;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (accept) begin
            if (item_i.op == OP_START) begin
              step_q    <= PHASE_W'(item_i.freq_hz);
              length_q  <= item_i.duration_samples;
              cursor_q  <= '0;
              phase_q   <= '0;
              playing_q <= 1'b1;
            end else if (!sounding && playing_q) begin
              playing_q <= 1'b0;
              cursor_q  <= '0;
            end
          end
        end
        ST_FREQ:  step_q <= cs_res[PHASE_W-1:0];
        ST_DIV:   cnt_q  <= cnt_q + 1'b1;
        ST_PHASE: begin
          cursor_q <= cursor_q + 1'b1;
          phase_q  <= cs_res[PHASE_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // divider and result path: payload only
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        rem_q <= prod[PROD_W-1:MAG_W];
        dvd_q <= prod[MAG_W-1:0];
        pos_q <= (phase_q != '0) && (CSUB_W'({phase_q, 1'b0}) < RATE_EXT);
        res_q <= '{sample: '0, active: 1'b0};
      end
      ST_DIV: begin
        rem_q <= cs_res[LEN_W-1:0];
        dvd_q <= {dvd_q[MAG_W-2:0], cs_ge};
      end
      ST_PHASE: begin
        res_q.sample <= pos_q ? $signed(mag_smp) : $signed(-mag_smp);
        res_q.active <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/decaying_square_tone_generator.sv =====
// ----------------------------------------------------------------------------
// decaying_square_tone_generator: beeper producing one audio sample per tick
// Square-wave tone with a linear decay envelope, streamed in and out.
// ----------------------------------------------------------------------------
// A start word (tuser = 1) loads a frequency in Hz and a length in samples,
// restarts the beep and produces no output. Each tick word (tuser = 0) yields
// one output word: while the beep sounds, the sample is
// +/- floor(PEAK_AMPLITUDE * (length - cursor) / length), saturated to 8191,
// positive while the phase sits strictly between zero and half the sample
// rate; after the beep the sample is zero and tuser (active) is low. A tick
// that sounds passes through the 15-step restoring divider, which shares
// one compare-and-subtract unit with the phase wrap; a start word reduces
// the frequency modulo the sample rate by repeated subtraction. The input
// stays stalled while a word is in progress; a finished sample sits in
// the output register, so the next word is taken while it waits downstream.
// ----------------------------------------------------------------------------
module decaying_square_tone_generator
  import dstg_pkg::*;
#(
  parameter int unsigned FS_HZ          = 44100,
  parameter int unsigned PEAK_AMPLITUDE = 8000
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [14:0] freq_hz, [36:15] duration_samples, [39:37] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] op: 0 tick, 1 start
  input  logic                   s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [13:0] sample (signed), [15:14] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [0] active
  output logic                   m_axis_tuser_o
);

  item_t   item;
  result_t eng_res;
  logic    eng_valid;
  logic    eng_take;
  logic    out_valid_q;
  result_t out_q;

  // unpack the input word
  assign item.op               = s_axis_tuser_i;
  assign item.freq_hz          = s_axis_tdata_i[FREQ_W-1:0];
  assign item.duration_samples = s_axis_tdata_i[FREQ_W+LEN_W-1:FREQ_W];

  dstg_engine #(
    .FS_HZ          (FS_HZ),
    .PEAK_AMPLITUDE (PEAK_AMPLITUDE)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid_i),
    .item_i       (item),
    .ready_o      (s_axis_tready_o),
    .res_valid_o  (eng_valid),
    .res_o        (eng_res),
    .res_take_i   (eng_take)
  );

  // move a finished sample into the output register whenever it is free
  assign eng_take = eng_valid & (~out_valid_q | m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_take) begin
      out_q <= eng_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - SMP_W){1'b0}}, out_q.sample};
  assign m_axis_tuser_o  = out_q.active;

endmodule
